// ===== src/cccw_pkg.sv =====
`timescale 1ns / 1ps

package cccw_pkg;

  // Field widths
  localparam int AMT_W      = 13;
  localparam int CNT_W      = 64;
  localparam int AMT_MAX    = 8191;

  // Denominations, one table column each
  localparam int NUM_COINS  = 11;
  localparam int LAST_COIN  = NUM_COINS - 1;
  localparam int ROW_STRIDE = NUM_COINS;
  localparam int T_W        = 4;

  // Control from the top level to the sequencer
  typedef struct packed {
    logic start;
    logic take;
  } ctrl_req_t;

  // Status from the sequencer to the top level
  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

  // Denomination of column t, in units of five cents
  function automatic int coin_units(input logic [T_W-1:0] t);
    int c;
    case (t)
      4'd0:    c = 1;
      4'd1:    c = 2;
      4'd2:    c = 4;
      4'd3:    c = 10;
      4'd4:    c = 20;
      4'd5:    c = 40;
      4'd6:    c = 100;
      4'd7:    c = 200;
      4'd8:    c = 400;
      4'd9:    c = 1000;
      4'd10:   c = 2000;
      default: c = 0;
    endcase
    return c;
  endfunction

  // Distance from row v column 0 back to row v-c_t column t
  function automatic int back_offset(input logic [T_W-1:0] t);
    int ofs;
    ofs = coin_units(t) * ROW_STRIDE - int'(t);
    return ofs;
  endfunction

endpackage

// ===== src/cccw_table.sv =====
`timescale 1ns / 1ps

module cccw_table #(
  parameter int DEPTH  = 90112,
  parameter int ADDR_W = 17
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [cccw_pkg::CNT_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [cccw_pkg::CNT_W-1:0]  rd_data
);
  import cccw_pkg::*;

  logic [CNT_W-1:0] mem [0:DEPTH-1];
  logic [CNT_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cccw_ctrl.sv =====
`timescale 1ns / 1ps

module cccw_ctrl #(
  parameter int MAX_UNITS = 8191,
  parameter int ADDR_W    = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cccw_pkg::ctrl_req_t         req_i,
  input  logic [cccw_pkg::AMT_W-1:0]  amount_i,
  output cccw_pkg::ctrl_stat_t        stat_o,
  output logic [cccw_pkg::CNT_W-1:0]  result_o,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [cccw_pkg::CNT_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [cccw_pkg::CNT_W-1:0]  rd_data
);
  import cccw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_ONE  = 2'd1;
  localparam logic [1:0] SEL_MEM  = 2'd2;

  localparam logic [T_W-1:0] T_FIRST = T_W'(1);
  localparam logic [T_W-1:0] T_LAST  = T_W'(LAST_COIN);

  logic [2:0]        state_r, state_nxt;
  logic [AMT_W-1:0]  filled_r, filled_nxt;
  logic [ADDR_W-1:0] fbase_r, fbase_nxt;
  logic [AMT_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [AMT_W-1:0]  amt_r, amt_nxt;
  logic [ADDR_W-1:0] look_addr_r, look_addr_nxt;
  logic [CNT_W-1:0]  result_r, result_nxt;
  logic [CNT_W-1:0]  acc_r;

  // Write stage, one step behind the read issue
  logic              sv_r, sv_nxt;
  logic [T_W-1:0]    swt_r, swt_nxt;
  logic [1:0]        ssel_r, ssel_nxt;
  logic [ADDR_W-1:0] swaddr_r, swaddr_nxt;

  int               coin;
  logic [1:0]       iss_sel;
  logic [CNT_W-1:0] addend;
  logic [CNT_W-1:0] acc_in;
  logic [CNT_W-1:0] acc_nxt;

  // Classify the earlier row that column t_r leans on
  always_comb begin
    coin = coin_units(t_r);
    if (int'(row_r) > coin) begin
      iss_sel = SEL_MEM;
    end else if (int'(row_r) == coin) begin
      iss_sel = SEL_ONE;
    end else begin
      iss_sel = SEL_ZERO;
    end
  end

  // Read issue: fill steps or the final lookup
  always_comb begin
    rd_en   = ((state_r == ST_FILL) && (iss_sel == SEL_MEM)) || (state_r == ST_LOOK);
    rd_addr = (state_r == ST_LOOK) ? look_addr_r
                                   : base_r - ADDR_W'(back_offset(t_r));
  end

  // Add and write back; column 0 is one and never stored
  always_comb begin
    case (ssel_r)
      SEL_MEM: addend = rd_data;
      SEL_ONE: addend = CNT_W'(1);
      default: addend = '0;
    endcase
    acc_in  = (swt_r == T_FIRST) ? CNT_W'(1) : acc_r;
    acc_nxt = acc_in + addend;
    wr_en   = sv_r;
    wr_addr = swaddr_r;
    wr_data = acc_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    fbase_nxt     = fbase_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    t_nxt         = t_r;
    amt_nxt       = amt_r;
    look_addr_nxt = look_addr_r;
    result_nxt    = result_r;
    sv_nxt        = 1'b0;
    swt_nxt       = t_r;
    ssel_nxt      = iss_sel;
    swaddr_nxt    = base_r + ADDR_W'(t_r);
    case (state_r)
      ST_IDLE: begin
        if (req_i.start) begin
          amt_nxt       = amount_i;
          look_addr_nxt = ADDR_W'(int'(amount_i) * ROW_STRIDE + LAST_COIN);
          row_nxt       = AMT_W'(filled_r + 1'b1);
          base_nxt      = fbase_r + ADDR_W'(ROW_STRIDE);
          t_nxt         = T_FIRST;
          if (int'(amount_i) > MAX_UNITS) begin
            result_nxt = '0;
            state_nxt  = ST_RESP;
          end else if (amount_i == '0) begin
            result_nxt = CNT_W'(1);
            state_nxt  = ST_RESP;
          end else if (amount_i <= filled_r) begin
            state_nxt = ST_LOOK;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        sv_nxt = 1'b1;
        if (t_r == T_LAST) begin
          filled_nxt = row_r;
          fbase_nxt  = base_r;
          if (row_r == amt_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            row_nxt  = AMT_W'(row_r + 1'b1);
            base_nxt = base_r + ADDR_W'(ROW_STRIDE);
            t_nxt    = T_FIRST;
          end
        end else begin
          t_nxt = T_W'(t_r + 1'b1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        result_nxt = rd_data;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (req_i.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      filled_r <= '0;
      fbase_r  <= '0;
      sv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      fbase_r  <= fbase_nxt;
      sv_r     <= sv_nxt;
    end
  end

  // Payload and step state
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    base_r      <= base_nxt;
    t_r         <= t_nxt;
    amt_r       <= amt_nxt;
    look_addr_r <= look_addr_nxt;
    result_r    <= result_nxt;
    swt_r       <= swt_nxt;
    ssel_r      <= ssel_nxt;
    swaddr_r    <= swaddr_nxt;
    if (sv_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign stat_o.idle = (state_r == ST_IDLE);
  assign stat_o.done = (state_r == ST_RESP);
  assign result_o    = result_r;

  // A step never reads the entry being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("table read and write hit the same entry");

  // A lookup only reads rows already filled
  a_look_filled: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOK |-> amt_r <= filled_r && amt_r != '0)
    else $error("lookup above the frontier");

  // Writes land on columns one through ten only
  a_write_col: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> swt_r >= T_FIRST && swt_r <= T_LAST)
    else $error("write to a column outside the stored range");

  // A waiting result holds until taken
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESP && !req_i.take |=> state_r == ST_RESP && $stable(result_r))
    else $error("result dropped before it was taken");

endmodule

// ===== src/coin_change_way_counter_core.sv =====
// Counts the ways to make in_amount_units (units of five cents) from eleven
// denominations, modulo 2^64; an amount above MAX_UNITS returns 0. Rows of
// partial counts stay in one single-port-write RAM and grow up to a frontier.
// A query at or below the frontier passes the sequencer, one RAM read and the
// result register before out_valid; a zero or out-of-range amount skips the
// RAM read. Each new row above the frontier takes one read-add-write step per
// stored column, paced by the RAM's single read port, and a query that fills
// rows then drains to let the last write land. One query is in progress at a
// time; a new one is taken while the previous result still waits on out_stall.
// Reset needs no clearing pass.
`timescale 1ns / 1ps

module coin_change_way_counter_core #(
  parameter int MAX_UNITS = 8191
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cccw_pkg::AMT_W-1:0]  in_amount_units,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cccw_pkg::CNT_W-1:0]  out_way_count
);
  import cccw_pkg::*;

  localparam int ROWS   = ((MAX_UNITS < AMT_MAX) ? MAX_UNITS : AMT_MAX) + 1;
  localparam int DEPTH  = ROWS * ROW_STRIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  ctrl_req_t         req;
  ctrl_stat_t        stat;
  logic [CNT_W-1:0]  result;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_data;

  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_way_count_r;

  // Take a beat only when the sequencer is free
  assign in_stall  = !stat.idle;
  assign req.start = in_valid && stat.idle;
  assign req.take  = stat.done && (!out_valid_r || !out_stall);

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (req.take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.take) begin
      out_way_count_r <= result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_way_count = out_way_count_r;

  cccw_ctrl #(
    .MAX_UNITS (MAX_UNITS),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_i    (req),
    .amount_i (in_amount_units),
    .stat_o   (stat),
    .result_o (result),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  cccw_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== dv/coin_ways_checker.sv =====
`timescale 1ns / 1ps

module coin_ways_checker #(
  parameter int MAX_UNITS = 8191
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [cccw_pkg::AMT_W-1:0]  in_amount_units,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [cccw_pkg::CNT_W-1:0]  out_way_count,
  output int                          mismatches,
  output int                          pending,
  output int                          checked
);
  import cccw_pkg::*;

  localparam int ROWS  = MAX_UNITS + 1;
  localparam int COINS = NUM_COINS;

  typedef struct {
    logic [AMT_W-1:0] amount;
    logic [CNT_W-1:0] count;
  } way_query_t;

  // Partial counts: entry t of row v uses only the first t+1 denominations
  logic [CNT_W-1:0] way_rows [ROWS*COINS];
  int unsigned      denom [COINS];
  int unsigned      row_frontier;
  way_query_t       counts_due [$];

  initial begin
    denom = '{1, 2, 4, 10, 20, 40, 100, 200, 400, 1000, 2000};
  end

  // Fill rows up to the amount on demand, then read the full-set count
  function automatic logic [CNT_W-1:0] count_ways(input logic [AMT_W-1:0] amount);
    int unsigned      v;
    int unsigned      base;
    logic [CNT_W-1:0] acc;
    if (int'(amount) > MAX_UNITS) return '0;
    while (row_frontier < amount) begin
      row_frontier++;
      v = row_frontier;
      base = v * COINS;
      way_rows[base] = 1;
      for (int t = 1; t < COINS; t++) begin
        acc = way_rows[base + t - 1];
        if (v >= denom[t]) acc += way_rows[(v - denom[t]) * COINS + t];
        way_rows[base + t] = acc;
      end
    end
    return way_rows[int'(amount) * COINS + COINS - 1];
  endfunction

  // Sample both channels mid-cycle; a beat seen here is taken at the next edge
  always @(negedge clk) begin
    way_query_t q;
    way_query_t want;
    if (!rst_n) begin
      for (int t = 0; t < COINS; t++) way_rows[t] = 1;
      row_frontier = 0;
      counts_due.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (in_valid && !in_stall) begin
        q.amount = in_amount_units;
        q.count = count_ways(in_amount_units);
        counts_due.push_back(q);
      end
      if (out_valid && !out_stall) begin
        if (counts_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no query waiting: expected none, actual %0d",
                   $time, out_way_count);
        end else begin
          want = counts_due.pop_front();
          checked++;
          if (out_way_count !== want.count) begin
            mismatches++;
            $display("%0t: way_count for amount %0d: expected %0d, actual %0d",
                     $time, want.amount, want.count, out_way_count);
          end
        end
      end
    end
    pending = counts_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cccw_pkg::*;

  localparam int MAX_UNITS   = 8191;
  localparam int RANDOM_QRYS = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 16;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [AMT_W-1:0] in_amount_units;
  logic             out_valid;
  logic             out_stall;
  logic [CNT_W-1:0] out_way_count;

  int mismatches;
  int pending;
  int checked;
  int sent;
  int top_amount;
  int cycles;
  bit no_idle;

  coin_change_way_counter_core #(
    .MAX_UNITS(MAX_UNITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_amount_units(in_amount_units),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_way_count(out_way_count)
  );

  coin_ways_checker #(
    .MAX_UNITS(MAX_UNITS)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_amount_units(in_amount_units),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_way_count(out_way_count),
    .mismatches(mismatches),
    .pending(pending),
    .checked(checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("coin_change_way_counter_core: mismatch");
      $finish;
    end
  end

  // Offer one amount after a random gap; return at the edge that takes it
  task automatic offer_amount(input int amount);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_amount_units <= amount[AMT_W-1:0];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sent++;
    if (amount > top_amount) top_amount = amount;
  endtask

  // Pick an amount: half the time push the frontier up a little, often reread old rows
  function automatic int pick_amount();
    int pick;
    int amount;
    pick = $urandom_range(0, 19);
    if (pick < 10) amount = top_amount + $urandom_range(0, 24);
    else if (pick < 19) amount = $urandom_range(0, top_amount);
    else amount = $urandom_range(0, AMT_MAX);
    if (amount > AMT_MAX) amount = AMT_MAX;
    return amount;
  endfunction

  // Result side: hold stall for a random count per beat, then open until taken
  initial begin
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin
    int directed [$];
    sent = 0;
    top_amount = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_amount_units <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Zero, each denomination and some of its neighbors, rereads below the frontier
    directed = '{0, 0, 1, 2, 3, 4, 5, 10, 3, 20, 40, 41, 100, 200, 400, 399,
                 1000, 2000, 2001, 1, 0, 1500};
    foreach (directed[i]) offer_amount(directed[i]);

    // Random queries; some stretches run with no idling on either side
    for (int i = 0; i < RANDOM_QRYS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      offer_amount(pick_amount());
    end
    no_idle = 1'b0;

    // Top row, a last fill if still short of it, and a reread just under it
    offer_amount(AMT_MAX);
    offer_amount(AMT_MAX - 1);
    offer_amount(0);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d amount queries reaching %0d units; checked %0d way counts.",
             sent, top_amount, checked);
    $display("Frontier grew in small steps and jumps, with rereads of filled rows.");
    if (mismatches == 0 && pending == 0) begin
      $display("coin_change_way_counter_core: match");
    end else begin
      $display("coin_change_way_counter_core: mismatch");
    end
    $finish;
  end

endmodule
